@@ rtl/core/lzss_pkg.sv @@
// Shared types and constants for the LZSS byte decompressor.
package lzss_pkg;

  localparam int DATA_W           = 8;
  localparam int FLAG_W           = 9;
  localparam int DIST_W           = 12;
  localparam int CNT_W            = 6;
  localparam int LEN_BIAS         = 3;
  localparam int WINDOW_DEPTH_DEF = 4096;

  localparam logic [FLAG_W-1:0] FLAG_MARK = FLAG_W'(9'h100);

  localparam logic FMT_NIBBLE = 1'b0;
  localparam logic FMT_FIVE   = 1'b1;

  typedef enum logic [2:0] {
    PH_FLAG   = 3'b001,
    PH_ITEM   = 3'b010,
    PH_SECOND = 3'b100
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RD   = 3'b010,
    ST_WR   = 3'b100
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic rd_issue;
    logic copy_write;
  } lzss_cmd_t;

  typedef struct packed {
    logic out_free;
    logic is_second;
    logic copy_done;
  } lzss_sts_t;

endpackage

@@ rtl/core/lzss_byte_decompressor.sv @@
// Top level of the LZSS byte decompressor.
//
//   channel | direction | tdata             | tlast          | notes
//   in_     | slave     | [7:0] data_byte   | end_of_stream  | compressed word
//   out_    | master    | [7:0] pixel       | last_in_run    | decompressed word
//   cfg_    | write     | [0] format_mode   | -              | no read-back
//
// Each byte of a back-reference copy is a history read followed by a history write
// on the history memory; no input word is accepted until the copy is done.
// Reset clears the parser, write pointer and output valid flag; history is not cleared.
// Output stalls back up into the copy loop and into in_tready.
module lzss_byte_decompressor import lzss_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] pixel
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  lzss_cmd_t cmd;
  lzss_sts_t sts;

  lzss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lzss_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_byte    (in_tdata),
    .in_eos     (in_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_byte   (out_tdata),
    .out_last   (out_tlast)
  );

endmodule

@@ rtl/core/lzss_ctrl.sv @@
// Controller state machine: accepts words and sequences back-reference copies.
module lzss_ctrl import lzss_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  lzss_sts_t sts,
  output lzss_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready  = sts.out_free;
        cmd.accept = in_tvalid && sts.out_free;
        if (cmd.accept && sts.is_second) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = ST_WR;
      end
      ST_WR: begin
        if (sts.out_free) begin
          cmd.copy_write = 1'b1;
          state_nxt      = sts.copy_done ? ST_IDLE : ST_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/lzss_dp.sv @@
// Datapath: parser registers, history memory, copy pointers and output register.
module lzss_dp import lzss_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [DATA_W-1:0] in_byte,
  input  logic              in_eos,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  lzss_cmd_t         cmd,
  output lzss_sts_t         sts,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_byte,
  output logic              out_last
);

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam logic [AW:0]   DEPTH_X  = (AW+1)'(WINDOW_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(WINDOW_DEPTH - 1);

  logic [DATA_W-1:0] mem [WINDOW_DEPTH];
  logic [DATA_W-1:0] rd_q;

  logic              fmt_r;
  phase_t            phase_r, phase_nxt;
  logic [FLAG_W-1:0] flag_r, flag_nxt;
  logic [DATA_W-1:0] held_r, held_nxt;
  logic [AW-1:0]     wp_r, wp_nxt;
  logic [AW-1:0]     src_r, src_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              eos_pend_r, eos_pend_nxt;
  logic              ov_r, ov_nxt;
  logic [DATA_W-1:0] ob_r, ob_nxt;
  logic              ol_r, ol_nxt;

  logic              mem_we;
  logic [DATA_W-1:0] mem_wdata;
  logic [DIST_W-1:0] back_dist;
  logic [CNT_W-1:0]  len;
  logic [AW:0]       diff;
  logic [AW-1:0]     src_start;
  logic [AW-1:0]     wp_inc;
  logic [AW-1:0]     src_inc;
  logic [FLAG_W-1:0] flag_adv;
  logic              out_free;

  assign out_free = !ov_r || out_tready;
  assign wp_inc   = (wp_r == LAST_IDX) ? '0 : wp_r + 1'b1;
  assign src_inc  = (src_r == LAST_IDX) ? '0 : src_r + 1'b1;
  assign flag_adv = flag_r >> 1;

  always_comb begin
    if (fmt_r == FMT_FIVE) begin
      back_dist = {1'b0, in_byte, held_r[7:5]};
      len       = CNT_W'({1'b0, held_r[4:0]}) + CNT_W'(LEN_BIAS);
    end else begin
      back_dist = {in_byte, held_r[7:4]};
      len       = CNT_W'({2'b00, held_r[3:0]}) + CNT_W'(LEN_BIAS);
    end
    diff = {1'b0, wp_r} - (AW+1)'(back_dist);
    if (diff[AW]) begin
      src_start = AW'(diff + DEPTH_X);
    end else begin
      src_start = diff[AW-1:0];
    end
  end

  assign sts.out_free  = out_free;
  assign sts.is_second = (phase_r == PH_SECOND);
  assign sts.copy_done = (cnt_r == CNT_W'(1));

  always_comb begin
    phase_nxt    = phase_r;
    flag_nxt     = flag_r;
    held_nxt     = held_r;
    wp_nxt       = wp_r;
    src_nxt      = src_r;
    cnt_nxt      = cnt_r;
    eos_pend_nxt = eos_pend_r;
    ov_nxt       = ov_r && !out_tready;
    ob_nxt       = ob_r;
    ol_nxt       = ol_r;
    mem_we       = 1'b0;
    mem_wdata    = rd_q;

    if (cmd.accept) begin
      unique case (phase_r)
        PH_ITEM: begin
          if (flag_r[0]) begin
            mem_we    = 1'b1;
            mem_wdata = in_byte;
            wp_nxt    = wp_inc;
            ov_nxt    = 1'b1;
            ob_nxt    = in_byte;
            ol_nxt    = 1'b1;
            flag_nxt  = flag_adv;
            phase_nxt = (flag_adv[FLAG_W-1:1] == '0) ? PH_FLAG : PH_ITEM;
          end else begin
            held_nxt  = in_byte;
            phase_nxt = PH_SECOND;
          end
        end
        PH_SECOND: begin
          cnt_nxt      = len;
          src_nxt      = src_start;
          eos_pend_nxt = in_eos;
          flag_nxt     = flag_adv;
          phase_nxt    = (flag_adv[FLAG_W-1:1] == '0) ? PH_FLAG : PH_ITEM;
        end
        default: begin
          flag_nxt  = FLAG_MARK | FLAG_W'(in_byte);
          phase_nxt = PH_ITEM;
        end
      endcase
      if (in_eos) begin
        phase_nxt = PH_FLAG;
        flag_nxt  = '0;
        held_nxt  = '0;
        if (phase_r != PH_SECOND) begin
          wp_nxt = '0;
        end
      end
    end

    if (cmd.copy_write) begin
      mem_we    = 1'b1;
      mem_wdata = rd_q;
      ov_nxt    = 1'b1;
      ob_nxt    = rd_q;
      ol_nxt    = (cnt_r == CNT_W'(1));
      cnt_nxt   = cnt_r - 1'b1;
      src_nxt   = src_inc;
      wp_nxt    = (cnt_r == CNT_W'(1) && eos_pend_r) ? '0 : wp_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r      <= FMT_NIBBLE;
      phase_r    <= PH_FLAG;
      flag_r     <= '0;
      held_r     <= '0;
      wp_r       <= '0;
      cnt_r      <= '0;
      eos_pend_r <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        fmt_r <= cfg_wdata;
      end
      phase_r    <= phase_nxt;
      flag_r     <= flag_nxt;
      held_r     <= held_nxt;
      wp_r       <= wp_nxt;
      cnt_r      <= cnt_nxt;
      eos_pend_r <= eos_pend_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r <= src_nxt;
    ob_r  <= ob_nxt;
    ol_r  <= ol_nxt;
  end

  // history: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp_r] <= mem_wdata;
    end
    if (cmd.rd_issue) begin
      rd_q <= mem[src_r];
    end
  end

  assign out_tvalid = ov_r;
  assign out_byte   = ob_r;
  assign out_last   = ol_r;

endmodule
